FILE: rtl/lfst_pkg.sv
// Shared types, constants and arithmetic helpers for the line-follow steer
// and corner-turn controller. No dependencies.
`default_nettype none

package lfst_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_DIR_MODE    = 3'd0;
    localparam logic [2:0] REG_ROUND_COUNT = 3'd1;
    localparam logic [2:0] REG_TARGET_YAW  = 3'd2;
    localparam logic [2:0] REG_GAIN_OUTER  = 3'd3;
    localparam logic [2:0] REG_GAIN_LOST   = 3'd4;
    localparam logic [2:0] REG_GAIN_MID    = 3'd5;
    localparam logic [2:0] REG_GAIN_INNER  = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int GAIN_W     = 11;
    localparam int STEER_W    = 12;
    localparam int DUTY_W     = 14;
    localparam int WIDE_W     = 18;

    // Course direction
    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    // Fixed steer values
    localparam logic signed [STEER_W-1:0] STEER_PAIR_LEFT  = -12'sd520;
    localparam logic signed [STEER_W-1:0] STEER_CENTER     = -12'sd50;
    localparam logic signed [STEER_W-1:0] STEER_PAIR_RIGHT = 12'sd416;

    // Duty constants (clockwise follow terms are in tenths)
    localparam logic signed [WIDE_W-1:0] CW_LEFT_BASE  = 18'sd26150;
    localparam logic signed [WIDE_W-1:0] CW_RIGHT_BASE = 18'sd25850;
    localparam logic signed [WIDE_W-1:0] CCW_LEFT_BASE  = 18'sd2595;
    localparam logic signed [WIDE_W-1:0] CCW_RIGHT_BASE = 18'sd2605;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 14'd10000;
    localparam logic [DUTY_W-1:0] DUTY_SLOW = 14'd1950;
    localparam logic [DUTY_W-1:0] DUTY_SLOWER = 14'd1900;
    localparam logic [DUTY_W-1:0] DUTY_TURN_FAST = 14'd4000;
    localparam logic [DUTY_W-1:0] DUTY_TURN_SLOW = 14'd2000;

    // Reciprocals: x/5 = (x*26215)>>17 for x < 8192, x/10 = (x*52429)>>19 for x < 65536
    localparam logic [14:0] DIV5_RECIP  = 15'd26215;
    localparam int          DIV5_SHIFT  = 17;
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [2:0] {
        PH_FOLLOW = 3'b001,
        PH_CORNER = 3'b010,
        PH_TURN   = 3'b100
    } t_phase;

    typedef struct packed {
        logic                dir_mode;
        logic [3:0]          round_count;
        logic [14:0]         target_yaw;
        logic [GAIN_W-1:0]   gain_outer;
        logic [GAIN_W-1:0]   gain_lost;
        logic [GAIN_W-1:0]   gain_mid;
        logic [GAIN_W-1:0]   outer_4_5;
        logic [GAIN_W-1:0]   mid_4_5;
        logic [GAIN_W-1:0]   inner_4_5;
        logic [GAIN_W-1:0]   inner_3_5;
    } t_cfg;

    function automatic logic [GAIN_W-1:0] div5(input logic [12:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'(DIV5_RECIP);
        return GAIN_W'(p >> DIV5_SHIFT);
    endfunction

    function automatic logic [GAIN_W-1:0] scale_4_5(input logic [GAIN_W-1:0] g);
        return div5({g, 2'b00});
    endfunction

    function automatic logic [GAIN_W-1:0] scale_3_5(input logic [GAIN_W-1:0] g);
        logic [12:0] t;
        t = 13'(g) + {1'b0, g, 1'b0};
        return div5(t);
    endfunction

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [WIDE_W-1:0] v);
        logic [DUTY_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({4'b0000, DUTY_MAX})) begin
            r = DUTY_MAX;
        end else begin
            r = v[DUTY_W-1:0];
        end
        return r;
    endfunction

    // Floor of a nonnegative value over ten; negative clamps to zero.
    function automatic logic signed [WIDE_W-1:0] tenth(input logic signed [WIDE_W-1:0] v);
        logic [31:0] p;
        logic signed [WIDE_W-1:0] r;
        p = 32'(v[15:0]) * 32'(DIV10_RECIP);
        if (v < 0) begin
            r = '0;
        end else begin
            r = $signed(WIDE_W'(p >> DIV10_SHIFT));
        end
        return r;
    endfunction

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] c;
        case (ph)
            PH_CORNER: c = 2'd1;
            PH_TURN:   c = 2'd2;
            default:   c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lfst_cfg_regs.sv
// Configuration register file with pre-scaled gain copies.
// Depends on lfst_pkg.
`default_nettype none

module lfst_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [lfst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lfst_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                  o_cfg_ready,
    output lfst_pkg::t_cfg                        o_cfg
);

    lfst_pkg::t_cfg r_cfg;
    lfst_pkg::t_cfg n_cfg;
    logic [lfst_pkg::GAIN_W-1:0] gain_wr;

    assign gain_wr = i_cfg_data[lfst_pkg::GAIN_W-1:0];

    // Scaled gains are computed at write time so the item path holds no divider
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                lfst_pkg::REG_DIR_MODE:    n_cfg.dir_mode    = i_cfg_data[0];
                lfst_pkg::REG_ROUND_COUNT: n_cfg.round_count = i_cfg_data[3:0];
                lfst_pkg::REG_TARGET_YAW:  n_cfg.target_yaw  = i_cfg_data[14:0];
                lfst_pkg::REG_GAIN_OUTER: begin
                    n_cfg.gain_outer = gain_wr;
                    n_cfg.outer_4_5  = lfst_pkg::scale_4_5(gain_wr);
                end
                lfst_pkg::REG_GAIN_LOST:   n_cfg.gain_lost   = gain_wr;
                lfst_pkg::REG_GAIN_MID: begin
                    n_cfg.gain_mid = gain_wr;
                    n_cfg.mid_4_5  = lfst_pkg::scale_4_5(gain_wr);
                end
                lfst_pkg::REG_GAIN_INNER: begin
                    n_cfg.inner_4_5 = lfst_pkg::scale_4_5(gain_wr);
                    n_cfg.inner_3_5 = lfst_pkg::scale_3_5(gain_wr);
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dir_mode    <= lfst_pkg::DIR_CW;
            r_cfg.round_count <= 4'd5;
            r_cfg.target_yaw  <= 15'd9000;
            r_cfg.gain_outer  <= '0;
            r_cfg.gain_lost   <= '0;
            r_cfg.gain_mid    <= '0;
            r_cfg.outer_4_5   <= '0;
            r_cfg.mid_4_5     <= '0;
            r_cfg.inner_4_5   <= '0;
            r_cfg.inner_3_5   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/lfst_steer_dec.sv
// Priority decode of the five line sensors into a signed steer value.
// Depends on lfst_pkg.
`default_nettype none

module lfst_steer_dec (
    input  wire logic [4:0]                              i_sensor_bits,
    input  wire lfst_pkg::t_cfg                          i_cfg,
    output logic signed [lfst_pkg::STEER_W-1:0]          o_steer
);

    logic s1, s2, s3, s4, s5;

    assign s1 = i_sensor_bits[0];
    assign s2 = i_sensor_bits[1];
    assign s3 = i_sensor_bits[2];
    assign s4 = i_sensor_bits[3];
    assign s5 = i_sensor_bits[4];

    // First match wins
    always_comb begin
        if (i_sensor_bits == 5'd0) begin
            o_steer = -$signed({1'b0, i_cfg.gain_lost});
        end else if (s1 && !s2 && !s3) begin
            o_steer = -$signed({1'b0, i_cfg.gain_outer});
        end else if (s1 && s2 && !s3) begin
            o_steer = lfst_pkg::STEER_PAIR_LEFT;
        end else if (!s1 && s2 && !s3) begin
            o_steer = -$signed({1'b0, i_cfg.gain_mid});
        end else if (!s1 && s2 && s3) begin
            o_steer = -$signed({1'b0, i_cfg.inner_4_5});
        end else if (!s1 && !s2 && s3 && !s4 && !s5) begin
            o_steer = lfst_pkg::STEER_CENTER;
        end else if (s3 && s4 && !s5) begin
            o_steer = $signed({1'b0, i_cfg.inner_3_5});
        end else if (!s3 && s4 && !s5) begin
            o_steer = $signed({1'b0, i_cfg.mid_4_5});
        end else if (!s3 && s4 && s5) begin
            o_steer = lfst_pkg::STEER_PAIR_RIGHT;
        end else if (!s3 && !s4 && s5) begin
            o_steer = $signed({1'b0, i_cfg.outer_4_5});
        end else begin
            o_steer = '0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lfst_duty_calc.sv
// Motor duty computation from course direction, turn phase and steer.
// Depends on lfst_pkg.
`default_nettype none

module lfst_duty_calc (
    input  wire logic                                    i_dir_mode,
    input  wire lfst_pkg::t_phase                        i_phase,
    input  wire logic signed [lfst_pkg::STEER_W-1:0]     i_steer,
    output logic [lfst_pkg::DUTY_W-1:0]                  o_pwm_left,
    output logic [lfst_pkg::DUTY_W-1:0]                  o_pwm_right
);

    logic signed [lfst_pkg::WIDE_W-1:0] steer_ext;
    logic signed [lfst_pkg::WIDE_W-1:0] steer_x13;
    logic signed [lfst_pkg::WIDE_W-1:0] cw_left;
    logic signed [lfst_pkg::WIDE_W-1:0] cw_right;
    logic signed [lfst_pkg::WIDE_W-1:0] ccw_left;
    logic signed [lfst_pkg::WIDE_W-1:0] ccw_right;
    logic signed [lfst_pkg::WIDE_W-1:0] left_raw;
    logic signed [lfst_pkg::WIDE_W-1:0] right_raw;

    assign steer_ext = {{(lfst_pkg::WIDE_W-lfst_pkg::STEER_W){i_steer[lfst_pkg::STEER_W-1]}},
                        i_steer};
    // 13*steer as shift-add
    assign steer_x13 = (steer_ext <<< 3) + (steer_ext <<< 2) + steer_ext;

    assign cw_left   = lfst_pkg::tenth(lfst_pkg::CW_LEFT_BASE - steer_x13);
    assign cw_right  = lfst_pkg::tenth(lfst_pkg::CW_RIGHT_BASE + steer_x13);
    assign ccw_left  = lfst_pkg::CCW_LEFT_BASE + steer_ext;
    assign ccw_right = lfst_pkg::CCW_RIGHT_BASE - steer_ext;

    always_comb begin
        left_raw  = '0;
        right_raw = '0;
        case (i_phase)
            lfst_pkg::PH_CORNER: begin
                if (i_dir_mode == lfst_pkg::DIR_CW) begin
                    left_raw  = $signed(lfst_pkg::WIDE_W'(lfst_pkg::DUTY_SLOW));
                    right_raw = $signed(lfst_pkg::WIDE_W'(lfst_pkg::DUTY_SLOWER));
                end else begin
                    left_raw  = $signed(lfst_pkg::WIDE_W'(lfst_pkg::DUTY_SLOWER));
                    right_raw = $signed(lfst_pkg::WIDE_W'(lfst_pkg::DUTY_SLOW));
                end
            end
            lfst_pkg::PH_TURN: begin
                if (i_dir_mode == lfst_pkg::DIR_CW) begin
                    left_raw  = $signed(lfst_pkg::WIDE_W'(lfst_pkg::DUTY_TURN_FAST));
                    right_raw = $signed(lfst_pkg::WIDE_W'(lfst_pkg::DUTY_TURN_SLOW));
                end else begin
                    left_raw  = $signed(lfst_pkg::WIDE_W'(lfst_pkg::DUTY_TURN_SLOW));
                    right_raw = $signed(lfst_pkg::WIDE_W'(lfst_pkg::DUTY_TURN_FAST));
                end
            end
            default: begin
                if (i_dir_mode == lfst_pkg::DIR_CW) begin
                    left_raw  = cw_left;
                    right_raw = cw_right;
                end else begin
                    left_raw  = ccw_left;
                    right_raw = ccw_right;
                end
            end
        endcase
    end

    assign o_pwm_left  = lfst_pkg::clamp_duty(left_raw);
    assign o_pwm_right = lfst_pkg::clamp_duty(right_raw);

endmodule

`default_nettype wire

FILE: rtl/line_follow_steer_and_turn_control_top.sv
// Line-follow steer and corner-turn controller, top level.
// Use: one input beat per control tick carries the five sensor bits and the
// signed yaw angle; one result beat comes back with both motor duties, the
// four direction pins, the held steer value, turn phase, corner count and
// the finished flag.
// Channels: input and result use valid/stall; a beat moves when valid is
// high and stall is low. Configuration uses valid/ready with a register
// index and data; ready is always high, write only while no beat is in flight.
// Path: a taken input beat goes to the input register, then one pass of
// decode, state update and duty math writes the result register. Throughput:
// one beat per cycle unless the result stalls, set by that single pass.
// Stall: a stalled result holds; the input register keeps taking a beat as
// long as the result register is free or being drained, and input stall
// rises only when both registers are full and the receiver stalls.
// Reset: synchronous, active low; clears the pipeline, the turn state
// (follow phase, count zero, steer zero, A1=0 A2=1 B1=0 B2=1) and loads the
// register defaults (clockwise, five laps, target 90.00 deg, gains zero).
// Depends on lfst_pkg, lfst_cfg_regs, lfst_steer_dec, lfst_duty_calc.
`default_nettype none

module line_follow_steer_and_turn_control_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [4:0]                          i_sensor_bits,
    input  wire logic signed [15:0]                  i_yaw,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [lfst_pkg::DUTY_W-1:0]              o_pwm_left,
    output logic [lfst_pkg::DUTY_W-1:0]              o_pwm_right,
    output logic                                     o_pin_a_one,
    output logic                                     o_pin_a_two,
    output logic                                     o_pin_b_one,
    output logic                                     o_pin_b_two,
    output logic signed [lfst_pkg::STEER_W-1:0]      o_steer,
    output logic [1:0]                               o_phase,
    output logic [5:0]                               o_corners_done,
    output logic                                     o_finished,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lfst_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lfst_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    lfst_pkg::t_cfg cfg;

    // Input register
    logic                r_in_valid;
    logic [4:0]          r_sensor;
    logic signed [15:0]  r_yaw;

    // Turn state
    lfst_pkg::t_phase                     r_phase, n_phase;
    logic [5:0]                           r_corner, n_corner;
    logic signed [lfst_pkg::STEER_W-1:0]  r_steer, n_steer;
    logic                                 r_done, n_done;
    logic                                 r_a1, r_a2, r_b1, r_b2;
    logic                                 n_a1, n_a2, n_b1, n_b2;

    // Result register
    logic                         r_out_valid;
    logic [lfst_pkg::DUTY_W-1:0]  r_pwm_left, r_pwm_right;

    logic                                 out_free;
    logic                                 in_free;
    logic                                 advance;
    logic signed [lfst_pkg::STEER_W-1:0]  dec_steer;
    logic [lfst_pkg::DUTY_W-1:0]          duty_left, duty_right;
    logic [15:0]                          yaw_mag;
    logic [5:0]                           last_corner;
    logic                                 corner_hit;
    logic                                 turning;

    lfst_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    lfst_steer_dec u_dec (
        .i_sensor_bits (r_sensor),
        .i_cfg         (cfg),
        .o_steer       (dec_steer)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_free  = !r_in_valid || out_free;
    assign advance  = r_in_valid && out_free;
    assign o_in_stall = !in_free;

    assign yaw_mag     = r_yaw[15] ? 16'(-r_yaw) : 16'(r_yaw);
    assign last_corner = {cfg.round_count, 2'b00} - 6'd1;
    assign corner_hit  = (cfg.dir_mode == lfst_pkg::DIR_CW) ? (&r_sensor[2:0])
                                                            : (&r_sensor[4:2]);

    always_comb begin
        n_phase  = r_phase;
        n_corner = r_corner;
        n_steer  = r_steer;
        n_done   = r_done;
        case (r_phase)
            lfst_pkg::PH_CORNER: begin
                if (r_corner == last_corner) begin
                    n_done = 1'b1;
                end else begin
                    n_corner = r_corner + 6'd1;
                    n_phase  = lfst_pkg::PH_TURN;
                end
            end
            lfst_pkg::PH_TURN: begin
                if ({1'b0, yaw_mag} >= {2'b00, cfg.target_yaw}) begin
                    n_phase = lfst_pkg::PH_FOLLOW;
                end
            end
            default: begin
                n_phase = corner_hit ? lfst_pkg::PH_CORNER : lfst_pkg::PH_FOLLOW;
                n_steer = dec_steer;
            end
        endcase
    end

    assign turning = (n_phase == lfst_pkg::PH_TURN);

    // Only the pins of the turning side follow the phase; the other pair holds
    always_comb begin
        n_a1 = r_a1;
        n_a2 = r_a2;
        n_b1 = r_b1;
        n_b2 = r_b2;
        if (cfg.dir_mode == lfst_pkg::DIR_CW) begin
            n_b1 = turning;
            n_b2 = !turning;
        end else begin
            n_a1 = turning;
            n_a2 = !turning;
        end
    end

    lfst_duty_calc u_duty (
        .i_dir_mode  (cfg.dir_mode),
        .i_phase     (n_phase),
        .i_steer     (n_steer),
        .o_pwm_left  (duty_left),
        .o_pwm_right (duty_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= lfst_pkg::PH_FOLLOW;
            r_corner    <= '0;
            r_steer     <= '0;
            r_done      <= 1'b0;
            r_a1        <= 1'b0;
            r_a2        <= 1'b1;
            r_b1        <= 1'b0;
            r_b2        <= 1'b1;
        end else begin
            if (in_free) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            // advance the turn state once per beat
            if (advance) begin
                r_phase  <= n_phase;
                r_corner <= n_corner;
                r_steer  <= n_steer;
                r_done   <= n_done;
                r_a1     <= n_a1;
                r_a2     <= n_a2;
                r_b1     <= n_b1;
                r_b2     <= n_b2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_sensor <= i_sensor_bits;
            r_yaw    <= i_yaw;
        end
        if (advance) begin
            r_pwm_left  <= duty_left;
            r_pwm_right <= duty_right;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pwm_left     = r_pwm_left;
    assign o_pwm_right    = r_pwm_right;
    assign o_pin_a_one    = r_a1;
    assign o_pin_a_two    = r_a2;
    assign o_pin_b_one    = r_b1;
    assign o_pin_b_two    = r_b2;
    assign o_steer        = r_steer;
    assign o_phase        = lfst_pkg::phase_code(r_phase);
    assign o_corners_done = r_corner;
    assign o_finished     = r_done;

endmodule

`default_nettype wire
